/* hdl/fys_pkg.sv */
// ----------------------------------------------------------------------------
// Fisher-Yates shuffle store package
// Shared widths, operation codes, controller states and the store command.
// ----------------------------------------------------------------------------
package fys_pkg;

    localparam int DATA_W       = 32;
    localparam int RND_W        = 31;
    localparam int POS_W        = 6;
    localparam int ADDR_W       = 6;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESET   = 2'd1,
        OP_SHUFFLE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RST_RD,
        S_RST_EMIT,
        S_DIV,
        S_SW_DATA,
        S_SW_WR2
    } t_state;

    // One write port and two read ports on the working copy, one of each on
    // the original copy.
    typedef struct packed {
        logic              wk_we;
        logic [ADDR_W-1:0] wk_addr;
        logic [DATA_W-1:0] wk_data;
        logic              org_we;
        logic [ADDR_W-1:0] org_addr;
        logic [DATA_W-1:0] org_data;
        logic              wk_rd_en;
        logic [ADDR_W-1:0] wk_rd_a;
        logic [ADDR_W-1:0] wk_rd_b;
        logic              org_rd_en;
        logic [ADDR_W-1:0] org_rd;
    } t_store_cmd;

endpackage

/* hdl/fys_rem.sv */
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module fys_rem #(
    parameter int CW = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [fys_pkg::RND_W-1:0] i_dividend,
    input  logic [CW-1:0]             i_divisor,
    output logic                      o_done,
    output logic [CW-1:0]             o_rem
);
    import fys_pkg::*;

    localparam int STEP_W = $clog2(RND_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [RND_W-1:0]  r_shift;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_div;
    logic [CW:0]       trial;
    logic [CW-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_shift[RND_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = CW'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(RND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= r_shift << 1;
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/fys_store.sv */
// ----------------------------------------------------------------------------
// Element store
// Working and original copies of the array, each a synchronous memory with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module fys_store #(
    parameter int CAPACITY = fys_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  fys_pkg::t_store_cmd        i_cmd,
    output logic [fys_pkg::DATA_W-1:0] o_rd_a,
    output logic [fys_pkg::DATA_W-1:0] o_rd_b,
    output logic [fys_pkg::DATA_W-1:0] o_rd_org
);
    import fys_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_W-1:0] r_work [CAPACITY];
    logic [DATA_W-1:0] r_orig [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wk_we) begin
            r_work[i_cmd.wk_addr[IDX_W-1:0]] <= i_cmd.wk_data;
        end
        if (i_cmd.wk_rd_en) begin
            o_rd_a <= r_work[i_cmd.wk_rd_a[IDX_W-1:0]];
            o_rd_b <= r_work[i_cmd.wk_rd_b[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.org_we) begin
            r_orig[i_cmd.org_addr[IDX_W-1:0]] <= i_cmd.org_data;
        end
        if (i_cmd.org_rd_en) begin
            o_rd_org <= r_orig[i_cmd.org_rd[IDX_W-1:0]];
        end
    end

endmodule

/* hdl/fisher_yates_shuffle_store_core.sv */
// Load item: no result, input stays open. Shuffle step: the 31-step remainder
// unit runs, then both entries are read and written back in turn; the result is
// offered with the first write-back. Reset item: each element is read from the
// original copy, then emitted and written back. Output stalls delay both.
// One item is worked at a time. Synchronous active-low reset clears the count
// and position and closes the load; both memories are undefined until written.
// ----------------------------------------------------------------------------
// Fisher-Yates shuffle store core
// Controller around the element store and the remainder unit.
// ----------------------------------------------------------------------------
module fisher_yates_shuffle_store_core #(
    parameter int CAPACITY = fys_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_operation,
    input  logic signed [fys_pkg::DATA_W-1:0] i_value,
    input  logic                              i_load_last,
    input  logic [fys_pkg::RND_W-1:0]         i_random_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [fys_pkg::DATA_W-1:0] o_element,
    output logic [fys_pkg::POS_W-1:0]         o_position,
    output logic                              o_last
);
    import fys_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_closed, n_closed;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic              r_o_valid, n_o_valid;
    logic [DATA_W-1:0] r_o_elem, n_o_elem;
    logic [IDX_W-1:0]  r_o_pos, n_o_pos;
    logic              r_o_last, n_o_last;

    t_op               op;
    t_store_cmd        cmd;
    logic [DATA_W-1:0] rd_a, rd_b, rd_org;
    logic              div_start, div_done;
    logic [CW-1:0]     div_rem;
    logic [CW-1:0]     divisor;
    logic [CW-1:0]     cnt_base;
    logic [IDX_W-1:0]  sh_i, sw_j;
    logic [CW-1:0]     k_next, i_next;
    logic              out_free;

    assign op       = t_op'(i_operation);
    assign out_free = !r_o_valid || !i_stall;
    assign cnt_base = r_closed ? '0 : r_count;
    // A stale position at or past the count restarts the pass at zero.
    assign sh_i     = (CW'(r_pos) >= r_count) ? '0 : r_pos;
    assign divisor  = r_count - CW'(sh_i);
    assign sw_j     = IDX_W'(CW'(r_i) + div_rem);
    assign k_next   = CW'(r_k) + 1'b1;
    assign i_next   = CW'(r_i) + 1'b1;

    fys_rem #(
        .CW (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_random_word),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    fys_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .o_rd_a   (rd_a),
        .o_rd_b   (rd_b),
        .o_rd_org (rd_org)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_closed  = r_closed;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_o_valid = r_o_valid && i_stall;
        n_o_elem  = r_o_elem;
        n_o_pos   = r_o_pos;
        n_o_last  = r_o_last;
        div_start = 1'b0;
        cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (op)
                        OP_LOAD: begin
                            if (r_closed) begin
                                n_pos = '0;
                            end
                            n_count = cnt_base;
                            // Elements past capacity are dropped.
                            if (cnt_base < CW'(CAPACITY)) begin
                                cmd.wk_we    = 1'b1;
                                cmd.wk_addr  = ADDR_W'(cnt_base[IDX_W-1:0]);
                                cmd.wk_data  = i_value;
                                cmd.org_we   = 1'b1;
                                cmd.org_addr = ADDR_W'(cnt_base[IDX_W-1:0]);
                                cmd.org_data = i_value;
                                n_count      = cnt_base + 1'b1;
                            end
                            n_closed = i_load_last;
                        end
                        OP_RESET: begin
                            n_pos = '0;
                            if (r_count != '0) begin
                                n_k     = '0;
                                n_state = S_RST_RD;
                            end
                        end
                        OP_SHUFFLE: begin
                            if (r_count != '0) begin
                                n_i       = sh_i;
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        OP_NONE: begin
                        end
                    endcase
                end
            end
            S_RST_RD: begin
                cmd.org_rd_en = 1'b1;
                cmd.org_rd    = ADDR_W'(r_k);
                n_state       = S_RST_EMIT;
            end
            S_RST_EMIT: begin
                if (out_free) begin
                    cmd.wk_we   = 1'b1;
                    cmd.wk_addr = ADDR_W'(r_k);
                    cmd.wk_data = rd_org;
                    n_o_valid   = 1'b1;
                    n_o_elem    = rd_org;
                    n_o_pos     = r_k;
                    n_o_last    = (k_next == r_count);
                    if (k_next == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_RST_RD;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    cmd.wk_rd_en = 1'b1;
                    cmd.wk_rd_a  = ADDR_W'(r_i);
                    cmd.wk_rd_b  = ADDR_W'(sw_j);
                    n_j          = sw_j;
                    n_state      = S_SW_DATA;
                end
            end
            S_SW_DATA: begin
                if (out_free) begin
                    cmd.wk_we   = 1'b1;
                    cmd.wk_addr = ADDR_W'(r_i);
                    cmd.wk_data = rd_b;
                    n_o_valid   = 1'b1;
                    n_o_elem    = rd_b;
                    n_o_pos     = r_i;
                    n_o_last    = (i_next == r_count);
                    n_state     = S_SW_WR2;
                end
            end
            S_SW_WR2: begin
                // When both indices match, this rewrites the same value.
                cmd.wk_we   = 1'b1;
                cmd.wk_addr = ADDR_W'(r_j);
                cmd.wk_data = rd_a;
                n_pos       = (i_next >= r_count) ? '0 : IDX_W'(i_next);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pos     <= '0;
            r_closed  <= 1'b1;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_closed  <= n_closed;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_o_elem <= n_o_elem;
        r_o_pos  <= n_o_pos;
        r_o_last <= n_o_last;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_element  = r_o_elem;
    assign o_position = POS_W'(r_o_pos);
    assign o_last     = r_o_last;

endmodule

/* hdl/fys_checker.sv */
// ----------------------------------------------------------------------------
// Fisher-Yates shuffle store port checker
// Watches the core's ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module fys_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic [1:0]                        i_operation,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [fys_pkg::DATA_W-1:0] o_element,
    input logic [fys_pkg::POS_W-1:0]         o_position,
    input logic                              o_last
);
    import fys_pkg::*;

    // A result that is stalled stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_element) && $stable(o_position)
            && $stable(o_last))
        else $error("stalled result changed or dropped");

    // A load or an unused operation finishes in the cycle it is taken.
    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == OP_LOAD || i_operation == OP_NONE)
            |=> !o_stall)
        else $error("load item held the input channel");

    // Results only come from an item being worked on.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while the block was idle");

    // The input channel only closes after an item has been taken.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("input stalled without an item");

endmodule

bind fisher_yates_shuffle_store_core fys_checker u_fys_checker (.*);
